// ===== hdl/fce_pkg.sv =====
package fce_pkg;

    localparam int MAX_SAMPLES = 64;
    localparam int COEF_DEPTH  = 65536;
    localparam int MAX_TERMS   = 64;
    localparam int MAX_WEIGHTS = 4;

    localparam int EXT_DEPTH = MAX_SAMPLES * MAX_SAMPLES;
    localparam int EXT_AW    = $clog2(EXT_DEPTH);
    localparam int COEF_AW   = $clog2(COEF_DEPTH);

    typedef enum logic [1:0] {
        OP_EXT_WR    = 2'd0,
        OP_COEF_WR   = 2'd1,
        OP_WEIGHT_WR = 2'd2,
        OP_EVAL      = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RESP,
        S_P_ADDR,
        S_P_READ,
        S_P_WRITE,
        S_T_START,
        S_T_ISSUE,
        S_T_DRAIN1,
        S_T_DRAIN2,
        S_T_MUL,
        S_T_ACC,
        S_FIN
    } state_t;

    typedef struct packed {
        op_t                opcode;
        logic [15:0]        table_address;
        logic [15:0]        extent_start;
        logic [6:0]         extent_length;
        logic signed [31:0] coefficient_value;
        logic               weight_side;
        logic [1:0]         weight_slot;
        logic [5:0]         control_index;
        logic signed [31:0] weight_value;
        logic [2:0]         incoming_count;
        logic [2:0]         outgoing_count;
        logic signed [31:0] cos_phi;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] channel_value;
        logic               is_evaluation;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic [15:0] start;
        logic [6:0]  length;
    } extent_t;

endpackage

// ===== hdl/fce_ram.sv =====
module fce_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/fourier_cosine_series_channel_eval.sv =====
// Fourier cosine-series channel evaluator. Extent, coefficient and weight-slot writes
// are acknowledged with a zero result, registered through S_RESP and the output
// register. An evaluate item with ni incoming and no outgoing slots (np = ni*no pairs)
// and nterms terms makes one extent read per pair, then one coefficient read per pair
// and term from the single port of the coefficient memory. At most 16 pairs and 64
// terms are handled. One item is in work at a time.
module fourier_cosine_series_channel_eval (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [6:0]        cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  fce_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output fce_pkg::out_item_t out_data
);
    import fce_pkg::*;

    localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;
    localparam logic signed [31:0] MONE_Q30 = -32'sd1073741824;
    localparam logic signed [63:0] OUT_MAX = 64'sd140737488355327;
    localparam logic signed [63:0] OUT_MIN = -64'sd140737488355328;

    state_t state_reg, state_next;

    logic [6:0] num_samples_reg;

    logic [5:0]         in_idx_reg  [MAX_WEIGHTS];
    logic signed [31:0] in_w_reg    [MAX_WEIGHTS];
    logic [5:0]         out_idx_reg [MAX_WEIGHTS];
    logic signed [31:0] out_w_reg   [MAX_WEIGHTS];

    logic [15:0]        pair_start_reg [16];
    logic [6:0]         pair_len_reg   [16];
    logic signed [29:0] pair_pw_reg    [16];

    logic [2:0] ni_reg, no_reg;
    logic [1:0] i_reg, o_reg;
    logic [6:0] nterms_reg, k_reg;
    logic       is_eval_reg;

    logic [13:0]        idx_reg;
    logic               idx_ok_reg;
    logic signed [63:0] wprod_reg;

    logic signed [31:0] c_reg, ck_reg, cprev_reg;

    logic               s1_valid_reg;
    logic signed [29:0] s1_pw_reg;
    logic               s2_valid_reg;
    logic signed [61:0] s2_prod_reg;
    logic signed [41:0] v_reg;
    logic signed [58:0] a_reg;
    logic signed [57:0] bq_reg;
    logic signed [63:0] cheb_reg;
    logic signed [63:0] acc_reg;

    logic      out_valid_reg;
    out_item_t out_data_reg;

    logic      accept, out_free, load_out;
    out_item_t out_next;
    logic      pair_last;
    logic [3:0] pair_sel;

    logic            ext_we, ext_re;
    logic [EXT_AW-1:0] ext_addr;
    extent_t         ext_wdata, ext_rdata;
    logic            coef_we, coef_re;
    logic [COEF_AW-1:0] coef_addr;
    logic [31:0]     coef_rdata;

    logic signed [31:0] cos_clamped;
    logic [2:0]         ni_cl, no_cl;
    logic [6:0]         len_cl;
    logic signed [29:0] pw_new;
    logic signed [37:0] term;
    logic signed [16:0] ch;
    logic signed [15:0] cl;
    logic signed [63:0] step;
    logic signed [33:0] cnext;
    logic signed [31:0] cnext_cl;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign pair_sel = {i_reg, o_reg};
    assign pair_last = !(3'(o_reg) + 3'd1 < no_reg) && !(3'(i_reg) + 3'd1 < ni_reg);

    assign cos_clamped = (in_data.cos_phi > ONE_Q30) ? ONE_Q30 :
                         (in_data.cos_phi < MONE_Q30) ? MONE_Q30 : in_data.cos_phi;
    assign ni_cl = (in_data.incoming_count > 3'(MAX_WEIGHTS)) ? 3'(MAX_WEIGHTS)
                                                               : in_data.incoming_count;
    assign no_cl = (in_data.outgoing_count > 3'(MAX_WEIGHTS)) ? 3'(MAX_WEIGHTS)
                                                               : in_data.outgoing_count;

    // memories
    assign ext_we    = accept && (in_data.opcode == OP_EXT_WR)
                       && (32'(in_data.table_address) < EXT_DEPTH);
    assign ext_re    = (state_reg == S_P_READ);
    assign ext_addr  = ext_re ? idx_reg[EXT_AW-1:0] : in_data.table_address[EXT_AW-1:0];
    assign ext_wdata = '{start: in_data.extent_start, length: in_data.extent_length};

    assign coef_we   = accept && (in_data.opcode == OP_COEF_WR)
                       && (32'(in_data.table_address) < COEF_DEPTH);
    assign coef_re   = (state_reg == S_T_ISSUE);
    assign coef_addr = coef_re ? COEF_AW'(32'(pair_start_reg[pair_sel]) + 32'(k_reg))
                               : COEF_AW'(in_data.table_address);

    fce_ram #(.WIDTH(23), .DEPTH(EXT_DEPTH)) u_ext_ram (
        .clk   (clk),
        .we    (ext_we),
        .re    (ext_re),
        .addr  (ext_addr),
        .wdata (ext_wdata),
        .rdata (ext_rdata)
    );

    fce_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef_ram (
        .clk   (clk),
        .we    (coef_we),
        .re    (coef_re),
        .addr  (coef_addr),
        .wdata (in_data.coefficient_value),
        .rdata (coef_rdata)
    );

    // arithmetic
    assign len_cl = !idx_ok_reg ? 7'd0 :
                    (ext_rdata.length > 7'(MAX_TERMS)) ? 7'(MAX_TERMS) : ext_rdata.length;
    assign pw_new = 30'((wprod_reg + 64'sd8589934592) >>> 34);
    assign term   = 38'((s2_prod_reg + 62'sd8388608) >>> 24);
    assign ch     = 17'(ck_reg >>> 15);
    assign cl     = $signed({1'b0, ck_reg[14:0]});
    assign step   = (64'(a_reg) + 64'(bq_reg >>> 15) + 64'sd16384) >>> 15;
    assign cnext  = 34'((cheb_reg + 64'sd268435456) >>> 29) - 34'(cprev_reg);
    assign cnext_cl = (cnext > 34'(ONE_Q30)) ? ONE_Q30 :
                      (cnext < 34'(MONE_Q30)) ? MONE_Q30 : 32'(cnext);

    always_comb
    begin
        out_next = '0;
        out_next.is_evaluation = is_eval_reg;
        if (is_eval_reg)
        begin
            if (acc_reg > OUT_MAX)
            begin
                out_next.channel_value = 48'(OUT_MAX);
                out_next.saturated     = 1'b1;
            end
            else if (acc_reg < OUT_MIN)
            begin
                out_next.channel_value = 48'(OUT_MIN);
                out_next.saturated     = 1'b1;
            end
            else
            begin
                out_next.channel_value = 48'(acc_reg);
            end
        end
    end

    assign load_out = ((state_reg == S_RESP) || (state_reg == S_FIN)) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_data.opcode == OP_EVAL && ni_cl != 3'd0 && no_cl != 3'd0)
                    begin
                        state_next = S_P_ADDR;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
            end
            S_RESP, S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_P_ADDR:   state_next = S_P_READ;
            S_P_READ:   state_next = S_P_WRITE;
            S_P_WRITE:  state_next = pair_last ? S_T_START : S_P_ADDR;
            S_T_START:  state_next = (nterms_reg == 7'd0) ? S_FIN : S_T_ISSUE;
            S_T_ISSUE:  state_next = pair_last ? S_T_DRAIN1 : S_T_ISSUE;
            S_T_DRAIN1: state_next = S_T_DRAIN2;
            S_T_DRAIN2: state_next = S_T_MUL;
            S_T_MUL:    state_next = S_T_ACC;
            S_T_ACC:    state_next = (k_reg + 7'd1 < nterms_reg) ? S_T_ISSUE : S_FIN;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            num_samples_reg <= 7'd3;
            out_valid_reg   <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            for (int n = 0; n < MAX_WEIGHTS; n++)
            begin
                in_idx_reg[n]  <= '0;
                in_w_reg[n]    <= '0;
                out_idx_reg[n] <= '0;
                out_w_reg[n]   <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            s1_valid_reg <= coef_re && (k_reg < pair_len_reg[pair_sel]);
            s2_valid_reg <= s1_valid_reg;
            if (cfg_we)
            begin
                num_samples_reg <= cfg_wdata;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (accept && in_data.opcode == OP_WEIGHT_WR
                && 3'(in_data.weight_slot) < 3'(MAX_WEIGHTS))
            begin
                if (in_data.weight_side)
                begin
                    out_idx_reg[in_data.weight_slot] <= in_data.control_index;
                    out_w_reg[in_data.weight_slot]   <= in_data.weight_value;
                end
                else
                begin
                    in_idx_reg[in_data.weight_slot] <= in_data.control_index;
                    in_w_reg[in_data.weight_slot]   <= in_data.weight_value;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= out_next;
        end

        s1_pw_reg   <= pair_pw_reg[pair_sel];
        s2_prod_reg <= 62'($signed(coef_rdata)) * 62'(s1_pw_reg);
        if (s2_valid_reg)
        begin
            v_reg <= v_reg + 42'(term);
        end

        unique case (state_reg)
            S_IDLE:
            begin
                is_eval_reg <= (in_data.opcode == OP_EVAL);
                ni_reg      <= ni_cl;
                no_reg      <= no_cl;
                i_reg       <= '0;
                o_reg       <= '0;
                nterms_reg  <= '0;
                k_reg       <= '0;
                acc_reg     <= '0;
                c_reg       <= cos_clamped;
                cprev_reg   <= cos_clamped;
                ck_reg      <= ONE_Q30;
            end
            S_P_ADDR:
            begin
                idx_reg <= 14'(in_idx_reg[i_reg]) * 14'(num_samples_reg)
                           + 14'(out_idx_reg[o_reg]);
            end
            S_P_READ:
            begin
                idx_ok_reg <= (32'(idx_reg) < EXT_DEPTH);
                wprod_reg  <= 64'(in_w_reg[i_reg]) * 64'(out_w_reg[o_reg]);
            end
            S_P_WRITE, S_T_ISSUE:
            begin
                if (state_reg == S_P_WRITE)
                begin
                    pair_start_reg[pair_sel] <= idx_ok_reg ? ext_rdata.start : 16'd0;
                    pair_len_reg[pair_sel]   <= len_cl;
                    pair_pw_reg[pair_sel]    <= pw_new;
                    if (len_cl > nterms_reg)
                    begin
                        nterms_reg <= len_cl;
                    end
                end
                if (3'(o_reg) + 3'd1 < no_reg)
                begin
                    o_reg <= o_reg + 2'd1;
                end
                else
                begin
                    o_reg <= '0;
                    i_reg <= (3'(i_reg) + 3'd1 < ni_reg) ? i_reg + 2'd1 : 2'd0;
                end
            end
            S_T_START:
            begin
                v_reg <= '0;
            end
            S_T_MUL:
            begin
                a_reg    <= 59'(v_reg) * 59'(ch);
                bq_reg   <= 58'(v_reg) * 58'(cl);
                cheb_reg <= 64'(c_reg) * 64'(ck_reg);
            end
            S_T_ACC:
            begin
                acc_reg   <= acc_reg + step;
                cprev_reg <= ck_reg;
                ck_reg    <= cnext_cl;
                k_reg     <= k_reg + 7'd1;
                v_reg     <= '0;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_term_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_ISSUE) |-> (k_reg < nterms_reg))
        else $error("term index beyond longest extent");

    a_cheb_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_MUL) |-> (ck_reg <= ONE_Q30 && ck_reg >= MONE_Q30))
        else $error("Chebyshev term out of range");

    a_pipe_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_T_MUL) |-> (!s1_valid_reg && !s2_valid_reg))
        else $error("term pipeline busy at step end");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && !is_eval_reg) |=>
        (out_valid && !out_data.is_evaluation && out_data.channel_value == 48'sd0))
        else $error("write acknowledge malformed");

endmodule
